### rtl/core/dfe_pkg.sv
// Shared constants, types and a helper function of the DShot frame encoder.
package dfe_pkg;

	// Frame and slot geometry.
	localparam int BUFFER_SLOTS = 18;
	localparam int FRAME_BITS   = 16;
	localparam int SLOT_W       = $clog2(BUFFER_SLOTS);
	localparam int BIT_IDX_W    = $clog2(FRAME_BITS);
	localparam int CRC_W        = 4;

	// Field widths.
	localparam int VALUE_W    = 11;
	localparam int CMP_W      = 16;
	localparam int FRAC_W     = 16;
	localparam int FRAC_MAG_W = 15;
	localparam int PROD_W     = FRAC_MAG_W + VALUE_W;

	// Q1.14 scaling constants.
	localparam int Q_ONE      = 16384;
	localparam int Q_SHIFT    = 14;
	localparam int ROUND_HALF = 8192;

	// Frame queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [VALUE_W-1:0] RESET_MIN_THROTTLE = VALUE_W'(48);
	localparam logic [VALUE_W-1:0] RESET_MAX_THROTTLE = VALUE_W'(2047);

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CMP_ZERO = 2'd0,
		REG_CMP_ONE  = 2'd1,
		REG_MIN_THR  = 2'd2,
		REG_MAX_THR  = 2'd3
	} cfg_reg_t;

	// Request kinds.
	localparam logic REQ_THROTTLE = 1'b0;
	localparam logic REQ_RAW      = 1'b1;

	typedef logic [FRAME_BITS-1:0] frame_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic head_valid;
	} q_status_t;

	// Value bits, a zero bit, then the XOR of the nibbles of value << 1.
	function automatic frame_t build_frame(input logic [VALUE_W-1:0] value);
		logic [VALUE_W:0] packet;
		logic [CRC_W-1:0] crc;
		packet = {value, 1'b0};
		crc    = packet[3:0] ^ packet[7:4] ^ packet[11:8];
		return {value, 1'b0, crc};
	endfunction

endpackage

### rtl/core/dshot_frame_encoder_top.sv
// Top level of the DShot frame encoder: configuration registers and wiring.
//
// Usage: each request on the input channel (in_valid / in_stall) yields one
// DShot frame as BUFFER_SLOTS timer compare values on the output channel
// (out_valid / out_stall): sixteen frame bits MSB first, then zero-valued
// pause slots, with last_slot high on the final slot of the frame.
// A throttle request scales a Q1.14 fraction onto [min_throttle, max_throttle];
// a raw request sends its 11-bit value as is.
// Path: an accepted request passes the two front stages, the frame queue and
// the output register before its first slot appears.
// Throughput: one slot per cycle while out_stall is low; BUFFER_SLOTS slots per
// request (18 by default), set by the back end's slot sequencer. A two-entry
// frame queue lets the front take new requests while the back is still sending.
// The user must write configuration via cfg_we/cfg_index/cfg_data only while idle (not enforced).
// Reset: compare values clear to zero, min_throttle to 48, max_throttle to
// 2047, and the pipeline, queue and slot counter are emptied.
// When the receiver stalls, the current slot is held on the outputs, the
// queue fills, and then in_stall rises until slots drain again.
module dshot_frame_encoder_top import dfe_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     req_type,
	input  logic signed [FRAC_W-1:0] throttle_fraction,
	input  logic [VALUE_W-1:0]       raw_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CMP_W-1:0]         compare_value,
	output logic                     last_slot,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	logic [CMP_W-1:0]   compare_for_zero_q;
	logic [CMP_W-1:0]   compare_for_one_q;
	logic [VALUE_W-1:0] min_throttle_q;
	logic [VALUE_W-1:0] max_throttle_q;

	q_status_t          q_status;
	logic               push;
	logic               pop;
	frame_t             push_frame;
	frame_t             head_frame;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_for_zero_q <= '0;
			compare_for_one_q  <= '0;
			min_throttle_q     <= RESET_MIN_THROTTLE;
			max_throttle_q     <= RESET_MAX_THROTTLE;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CMP_ZERO: compare_for_zero_q <= cfg_data[CMP_W-1:0];
				REG_CMP_ONE:  compare_for_one_q  <= cfg_data[CMP_W-1:0];
				REG_MIN_THR:  min_throttle_q     <= cfg_data[VALUE_W-1:0];
				REG_MAX_THR:  max_throttle_q     <= cfg_data[VALUE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dfe_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.req_type          (req_type),
		.throttle_fraction (throttle_fraction),
		.raw_value         (raw_value),
		.min_throttle      (min_throttle_q),
		.max_throttle      (max_throttle_q),
		.q_status          (q_status),
		.push              (push),
		.push_frame        (push_frame)
	);

	dfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head_frame (head_frame),
		.q_status   (q_status)
	);

	dfe_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_status         (q_status),
		.head_frame       (head_frame),
		.pop              (pop),
		.compare_for_zero (compare_for_zero_q),
		.compare_for_one  (compare_for_one_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.compare_value    (compare_value),
		.last_slot        (last_slot)
	);

endmodule

### rtl/core/dfe_front.sv
// Front end: accepts requests, scales throttle fractions and builds frames.
module dfe_front import dfe_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic signed [FRAC_W-1:0]  throttle_fraction,
	input  logic [VALUE_W-1:0]        raw_value,
	input  logic [VALUE_W-1:0]        min_throttle,
	input  logic [VALUE_W-1:0]        max_throttle,
	input  q_status_t                 q_status,
	output logic                      push,
	output frame_t                    push_frame
);

	logic                  s1_valid_q;
	logic                  s2_valid_q;
	logic                  s1_move;
	logic                  s2_move;
	logic                  accept;

	logic                  req_type_s1;
	logic [VALUE_W-1:0]    raw_s1;
	logic [FRAC_MAG_W-1:0] frac_s1;

	logic                  req_type_s2;
	logic [VALUE_W-1:0]    raw_s2;
	logic                  d_neg_s2;
	logic [PROD_W-1:0]     prod_s2;

	logic [FRAC_MAG_W-1:0] frac_clamped;
	logic [VALUE_W:0]      diff;
	logic                  d_neg;
	logic [VALUE_W-1:0]    d_abs;
	logic [PROD_W-1:0]     rounded;
	logic [VALUE_W-1:0]    q_val;
	logic [VALUE_W-1:0]    value;

	// Pipeline flow control.
	assign s2_move  = s2_valid_q && !q_status.full;
	assign s1_move  = s1_valid_q && (!s2_valid_q || s2_move);
	assign in_stall = s1_valid_q && !(!s2_valid_q || s2_move);
	assign accept   = in_valid && !in_stall;

	// Clamp the Q1.14 fraction to the range zero to one.
	always_comb begin
		if (throttle_fraction[FRAC_W-1]) begin
			frac_clamped = '0;
		end else if (throttle_fraction > FRAC_W'(Q_ONE)) begin
			frac_clamped = FRAC_MAG_W'(Q_ONE);
		end else begin
			frac_clamped = throttle_fraction[FRAC_MAG_W-1:0];
		end
	end

	// Span between the throttle limits, as sign and magnitude.
	assign diff  = {1'b0, max_throttle} - {1'b0, min_throttle};
	assign d_neg = diff[VALUE_W];
	assign d_abs = d_neg ? VALUE_W'(-diff) : diff[VALUE_W-1:0];

	// Valid bits of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept || (s1_valid_q && !s1_move);
			s2_valid_q <= s1_move || (s2_valid_q && !s2_move);
		end
	end

	// Stage one: capture the request with the clamped fraction.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req_type;
			raw_s1      <= raw_value;
			frac_s1     <= frac_clamped;
		end
	end

	// Stage two: product of the fraction and the span magnitude.
	always_ff @(posedge clk) begin
		if (s1_move) begin
			req_type_s2 <= req_type_s1;
			raw_s2      <= raw_s1;
			d_neg_s2    <= d_neg;
			prod_s2     <= PROD_W'(frac_s1) * PROD_W'(d_abs);
		end
	end

	// Round half up, apply the sign and wrap onto eleven bits.
	assign rounded = prod_s2 + PROD_W'(ROUND_HALF);
	assign q_val   = rounded[Q_SHIFT +: VALUE_W];

	always_comb begin
		if (req_type_s2 == REQ_RAW) begin
			value = raw_s2;
		end else if (d_neg_s2) begin
			value = min_throttle - q_val;
		end else begin
			value = min_throttle + q_val;
		end
	end

	assign push       = s2_move;
	assign push_frame = build_frame(value);

	// Stage two must hold its item while the queue is full.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && q_status.full |=> s2_valid_q)
		else $error("front stage two dropped an item while the queue was full");

endmodule

### rtl/core/dfe_queue.sv
// Short frame queue between the front end and the slot sequencer.
module dfe_queue import dfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  frame_t    push_frame,
	input  logic      pop,
	output frame_t    head_frame,
	output q_status_t q_status
);

	frame_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_status.full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.head_valid = (count_q != '0);
	assign head_frame          = mem_q[rd_ptr_q];

	// Frame storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("frame queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_status.head_valid)
		else $error("frame queue read while empty");

endmodule

### rtl/core/dfe_back.sv
// Back end: walks the slots of the head frame and drives the output register.
module dfe_back import dfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  q_status_t        q_status,
	input  frame_t           head_frame,
	output logic             pop,
	input  logic [CMP_W-1:0] compare_for_zero,
	input  logic [CMP_W-1:0] compare_for_one,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [CMP_W-1:0] compare_value,
	output logic             last_slot
);

	logic [SLOT_W-1:0]    slot_q;
	logic                 out_valid_q;
	logic [CMP_W-1:0]     compare_value_q;
	logic                 last_slot_q;

	logic                 out_load;
	logic                 is_last;
	logic                 is_frame_bit;
	logic [BIT_IDX_W-1:0] bit_idx;
	logic [CMP_W-1:0]     slot_cmp;

	// A slot is produced whenever a frame is queued and the output register is free or drains.
	assign out_load = q_status.head_valid && (!out_valid_q || !out_stall);
	assign is_last  = (slot_q == SLOT_W'(BUFFER_SLOTS - 1));
	assign pop      = out_load && is_last;

	// Frame bits go out MSB first; pause slots carry zero.
	assign is_frame_bit = ({1'b0, slot_q} < (SLOT_W + 1)'(FRAME_BITS));
	assign bit_idx      = BIT_IDX_W'(FRAME_BITS - 1) - slot_q[BIT_IDX_W-1:0];

	always_comb begin
		if (!is_frame_bit) begin
			slot_cmp = '0;
		end else if (head_frame[bit_idx]) begin
			slot_cmp = compare_for_one;
		end else begin
			slot_cmp = compare_for_zero;
		end
	end

	// Slot counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
			if (out_load) begin
				slot_q <= is_last ? '0 : slot_q + 1'b1;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			compare_value_q <= slot_cmp;
			last_slot_q     <= is_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign compare_value = compare_value_q;
	assign last_slot     = last_slot_q;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(BUFFER_SLOTS - 1))
		else $error("slot counter beyond the buffer");

	a_slot_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && is_last |=> slot_q == '0 && out_valid_q && last_slot_q)
		else $error("last slot did not end the frame");

endmodule
